[design/spisq_pkg.sv]
package spisq_pkg;

  // Field widths
  localparam int ADDR_W    = 24;
  localparam int CNT_W     = 16;
  localparam int MAX_RES   = 6;
  localparam int RES_CNT_W = 3;
  localparam int HDR_MAX   = 4;

  // Depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Device command bytes
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_SE    = 8'hD8;

  // Page sizes of the EEPROM types
  localparam int PAGE_SMALL  = 16;
  localparam int PAGE_EEPROM = 32;

  // Memory type codes
  localparam logic [1:0] MT_NONE   = 2'd0;
  localparam logic [1:0] MT_SMALL  = 2'd1;
  localparam logic [1:0] MT_EEPROM = 2'd2;
  localparam logic [1:0] MT_FLASH  = 2'd3;

  typedef enum logic [2:0] {
    OP_START_READ  = 3'd0,
    OP_READ_SLOT   = 3'd1,
    OP_START_WRITE = 3'd2,
    OP_WRITE_BYTE  = 3'd3,
    OP_STATUS      = 3'd4,
    OP_ERASE       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_RECV  = 2'd1,
    KIND_DESEL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_POLL  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  byte_count;
    logic [7:0]        data_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic [1:0] byte_kind;
    logic       end_frame;
    logic       last;
  } out_req_t;

  typedef struct packed {
    logic [1:0] mem_type;
  } cfg_req_t;

  // One SPI slot as queued between front and back
  typedef struct packed {
    logic [7:0] spi_byte;
    logic [1:0] byte_kind;
    logic       end_frame;
  } res_t;

  // All slots caused by one request, entry 0 goes out first
  typedef struct packed {
    logic [RES_CNT_W-1:0]  count;
    res_t [MAX_RES-1:0]    res;
  } job_t;

  // Command plus address bytes
  typedef struct packed {
    logic [2:0]             len;
    logic [HDR_MAX-1:0][7:0] b;
  } hdr_t;

endpackage

[design/spisq_chan_if.sv]
interface spisq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[design/spisq_fifo.sv]
module spisq_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && cnt_r != CW'(DEPTH)) |-> (rd_ptr_r != wr_ptr_r))
    else $error("queue pointers meet while partly filled");

endmodule

[design/spisq_front.sv]
module spisq_front #(
  parameter int FLASH_PAGE_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  spisq_chan_if.sink        in_ch,
  spisq_chan_if.sink        cfg_ch,
  input  logic              q_full,
  output logic              q_push,
  output spisq_pkg::job_t   q_job
);

  localparam int PAGE_MAX = (FLASH_PAGE_BYTES > spisq_pkg::PAGE_EEPROM) ?
                            FLASH_PAGE_BYTES : spisq_pkg::PAGE_EEPROM;
  localparam int PFW      = $clog2(PAGE_MAX + 1);
  localparam int AW       = spisq_pkg::ADDR_W;
  localparam int RCW      = spisq_pkg::RES_CNT_W;

  spisq_pkg::mode_t        mode_r, mode_nxt;
  logic [1:0]              mem_type_r;
  logic [AW-1:0]           cur_r, cur_nxt;
  logic [AW:0]             end_r, end_nxt;
  logic [PFW-1:0]          fill_r, fill_nxt;
  logic [spisq_pkg::CNT_W-1:0] rrem_r, rrem_nxt;

  logic                    acc;
  logic [2:0]              op;
  logic [AW-1:0]           addr;
  logic [spisq_pkg::CNT_W-1:0] cnt;
  logic [7:0]              db;
  logic                    is_idle;
  logic                    mt_on;
  logic [AW:0]             wr_nxt;
  logic                    wr_done;
  logic [PFW-1:0]          fill_inc;
  logic [PFW-1:0]          page_size;
  logic                    page_full;
  logic                    more;
  logic [spisq_pkg::CNT_W-1:0] rrem_dec;
  spisq_pkg::hdr_t         hdr_rd, hdr_new, hdr_cur;
  spisq_pkg::job_t         job;

  // Command byte plus address bytes for the current memory type
  function automatic spisq_pkg::hdr_t make_hdr(logic [1:0] mt, logic [7:0] cmd,
                                               logic [AW-1:0] a);
    spisq_pkg::hdr_t h;
    h = '0;
    if (mt == spisq_pkg::MT_SMALL) begin
      h.len  = 3'd2;
      h.b[0] = cmd | {4'b0, a[8], 3'b0};
      h.b[1] = a[7:0];
    end else if (mt == spisq_pkg::MT_EEPROM) begin
      h.len  = 3'd3;
      h.b[0] = cmd;
      h.b[1] = a[15:8];
      h.b[2] = a[7:0];
    end else begin
      h.len  = 3'd4;
      h.b[0] = cmd;
      h.b[1] = a[23:16];
      h.b[2] = a[15:8];
      h.b[3] = a[7:0];
    end
    return h;
  endfunction

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;

  assign acc     = in_ch.valid && in_ch.ready;
  assign op      = in_ch.payload.opcode;
  assign addr    = in_ch.payload.address;
  assign cnt     = in_ch.payload.byte_count;
  assign db      = in_ch.payload.data_byte;
  assign is_idle = (mode_r == spisq_pkg::MODE_IDLE);
  assign mt_on   = (mem_type_r != spisq_pkg::MT_NONE);

  // write progress: next address, end of data, page boundary
  assign wr_nxt    = {1'b0, cur_r} + (AW + 1)'(1);
  assign wr_done   = (wr_nxt >= end_r) || wr_nxt[AW];
  assign fill_inc  = fill_r + PFW'(1);
  assign page_size = (mem_type_r == spisq_pkg::MT_SMALL)  ? PFW'(spisq_pkg::PAGE_SMALL) :
                     (mem_type_r == spisq_pkg::MT_EEPROM) ? PFW'(spisq_pkg::PAGE_EEPROM) :
                                                            PFW'(FLASH_PAGE_BYTES);
  assign page_full = (fill_inc >= page_size);
  assign more      = ({1'b0, cur_r} < end_r);
  assign rrem_dec  = rrem_r - spisq_pkg::CNT_W'(1);

  assign hdr_rd  = make_hdr(mem_type_r, spisq_pkg::CMD_READ, addr);
  assign hdr_new = make_hdr(mem_type_r, spisq_pkg::CMD_WRITE, addr);
  assign hdr_cur = make_hdr(mem_type_r, spisq_pkg::CMD_WRITE, cur_r);

  // mode next state
  always_comb begin
    mode_nxt = mode_r;
    if (acc) begin
      case (op)
        spisq_pkg::OP_START_READ: begin
          if (is_idle && mt_on && cnt != '0) mode_nxt = spisq_pkg::MODE_READ;
        end
        spisq_pkg::OP_READ_SLOT: begin
          if (mode_r == spisq_pkg::MODE_READ && rrem_dec == '0) begin
            mode_nxt = spisq_pkg::MODE_IDLE;
          end
        end
        spisq_pkg::OP_START_WRITE: begin
          if (is_idle && mt_on && cnt != '0) mode_nxt = spisq_pkg::MODE_WRITE;
        end
        spisq_pkg::OP_WRITE_BYTE: begin
          if (mode_r == spisq_pkg::MODE_WRITE && (wr_done || page_full)) begin
            mode_nxt = spisq_pkg::MODE_POLL;
          end
        end
        spisq_pkg::OP_STATUS: begin
          if (mode_r == spisq_pkg::MODE_POLL && !db[0]) begin
            mode_nxt = (more && mt_on) ? spisq_pkg::MODE_WRITE : spisq_pkg::MODE_IDLE;
          end
        end
        spisq_pkg::OP_ERASE: begin
          if (is_idle && mem_type_r == spisq_pkg::MT_FLASH) mode_nxt = spisq_pkg::MODE_POLL;
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  // slot list and datapath next values
  always_comb begin
    job      = '0;
    cur_nxt  = cur_r;
    end_nxt  = end_r;
    fill_nxt = fill_r;
    rrem_nxt = rrem_r;
    if (acc) begin
      case (op)
        spisq_pkg::OP_START_READ: begin
          if (is_idle && mt_on) begin
            for (int i = 0; i < spisq_pkg::HDR_MAX; i++) begin
              if (3'(i) < hdr_rd.len) begin
                job.res[i] = '{hdr_rd.b[i], spisq_pkg::KIND_SEND,
                               (3'(i) == hdr_rd.len - 3'd1) && (cnt == '0)};
              end
            end
            job.count = RCW'(hdr_rd.len);
            if (cnt != '0) rrem_nxt = cnt;
          end
        end
        spisq_pkg::OP_READ_SLOT: begin
          if (mode_r == spisq_pkg::MODE_READ) begin
            rrem_nxt   = rrem_dec;
            job.res[0] = '{8'h00, spisq_pkg::KIND_RECV, rrem_dec == '0};
            job.count  = RCW'(1);
          end else if (mode_r == spisq_pkg::MODE_POLL) begin
            job.res[0] = '{8'h00, spisq_pkg::KIND_RECV, 1'b0};
            job.count  = RCW'(1);
          end
        end
        spisq_pkg::OP_START_WRITE: begin
          if (is_idle && mt_on && cnt != '0) begin
            cur_nxt    = addr;
            end_nxt    = {1'b0, addr} + {{(AW + 1 - spisq_pkg::CNT_W){1'b0}}, cnt};
            fill_nxt   = '0;
            job.res[0] = '{spisq_pkg::CMD_WREN, spisq_pkg::KIND_SEND, 1'b1};
            for (int i = 0; i < spisq_pkg::HDR_MAX; i++) begin
              if (3'(i) < hdr_new.len) begin
                job.res[i + 1] = '{hdr_new.b[i], spisq_pkg::KIND_SEND, 1'b0};
              end
            end
            job.count = RCW'(hdr_new.len + 3'd1);
          end
        end
        spisq_pkg::OP_WRITE_BYTE: begin
          if (mode_r == spisq_pkg::MODE_WRITE) begin
            fill_nxt = fill_inc;
            cur_nxt  = wr_nxt[AW-1:0];
            if (wr_done) end_nxt = {1'b0, wr_nxt[AW-1:0]};
            if (wr_done || page_full) begin
              job.res[0] = '{db, spisq_pkg::KIND_SEND, 1'b1};
              job.res[1] = '{spisq_pkg::CMD_RDSR, spisq_pkg::KIND_SEND, 1'b0};
              job.count  = RCW'(2);
            end else begin
              job.res[0] = '{db, spisq_pkg::KIND_SEND, 1'b0};
              job.count  = RCW'(1);
            end
          end
        end
        spisq_pkg::OP_STATUS: begin
          if (mode_r == spisq_pkg::MODE_POLL) begin
            if (db[0]) begin
              job.res[0] = '{8'h00, spisq_pkg::KIND_RECV, 1'b0};
              job.count  = RCW'(1);
            end else begin
              job.res[0] = '{8'h00, spisq_pkg::KIND_DESEL, 1'b1};
              job.count  = RCW'(1);
              // next page: write enable, then header at current address
              if (more && mt_on) begin
                fill_nxt   = '0;
                job.res[1] = '{spisq_pkg::CMD_WREN, spisq_pkg::KIND_SEND, 1'b1};
                for (int i = 0; i < spisq_pkg::HDR_MAX; i++) begin
                  if (3'(i) < hdr_cur.len) begin
                    job.res[i + 2] = '{hdr_cur.b[i], spisq_pkg::KIND_SEND, 1'b0};
                  end
                end
                job.count = RCW'(hdr_cur.len + 3'd2);
              end
            end
          end
        end
        spisq_pkg::OP_ERASE: begin
          if (is_idle && mem_type_r == spisq_pkg::MT_FLASH) begin
            cur_nxt    = {addr[AW-1:16], 16'h0000};
            end_nxt    = {1'b0, addr[AW-1:16], 16'h0000};
            job.res[0] = '{spisq_pkg::CMD_WREN, spisq_pkg::KIND_SEND, 1'b1};
            job.res[1] = '{spisq_pkg::CMD_SE, spisq_pkg::KIND_SEND, 1'b0};
            job.res[2] = '{addr[AW-1:16], spisq_pkg::KIND_SEND, 1'b0};
            job.res[3] = '{8'h00, spisq_pkg::KIND_SEND, 1'b0};
            job.res[4] = '{8'h00, spisq_pkg::KIND_SEND, 1'b1};
            job.res[5] = '{spisq_pkg::CMD_RDSR, spisq_pkg::KIND_SEND, 1'b0};
            job.count  = RCW'(spisq_pkg::MAX_RES);
          end
        end
        default: job = '0;
      endcase
    end
  end

  assign q_push = acc && (job.count != '0);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= spisq_pkg::MODE_IDLE;
      mem_type_r <= spisq_pkg::MT_NONE;
      cur_r      <= '0;
      end_r      <= '0;
      fill_r     <= '0;
      rrem_r     <= '0;
    end else begin
      mode_r <= mode_nxt;
      cur_r  <= cur_nxt;
      end_r  <= end_nxt;
      fill_r <= fill_nxt;
      rrem_r <= rrem_nxt;
      if (cfg_ch.valid) begin
        mem_type_r <= cfg_ch.payload.mem_type;
      end
    end
  end

  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (!q_full && q_job.count <= RCW'(spisq_pkg::MAX_RES)))
    else $error("request pushed into full queue or with too many slots");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == spisq_pkg::MODE_WRITE) |-> ({1'b0, cur_r} < end_r))
    else $error("write mode with no bytes left");

endmodule

[design/spisq_back.sv]
module spisq_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  spisq_pkg::job_t q_job,
  output logic            q_pop,
  spisq_chan_if.source    out_ch
);

  localparam int RCW = spisq_pkg::RES_CNT_W;

  spisq_pkg::res_t [spisq_pkg::MAX_RES-1:0] res_r, res_nxt;
  logic [RCW-1:0]     rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  spisq_pkg::out_req_t out_data_r, out_data_nxt;

  logic adv;
  logic busy;
  logic emit;
  logic load;

  assign adv  = !out_valid_r || out_ch.ready;
  assign busy = (rem_r != '0);
  assign emit = adv && busy;
  assign load = q_valid && (!busy || (emit && rem_r == RCW'(1)));

  assign q_pop          = load;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

  // slot shifter: entry 0 is the next slot to send
  always_comb begin
    res_nxt = res_r;
    rem_nxt = rem_r;
    if (load) begin
      res_nxt = q_job.res;
      rem_nxt = q_job.count;
    end else if (emit) begin
      res_nxt = res_r >> $bits(spisq_pkg::res_t);
      rem_nxt = rem_r - RCW'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (adv) begin
      out_valid_nxt = busy;
      out_data_nxt  = '{res_r[0].spi_byte, res_r[0].byte_kind, res_r[0].end_frame,
                        rem_r == RCW'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= RCW'(spisq_pkg::MAX_RES))
    else $error("slot count beyond one request's maximum");

endmodule

[design/spi_save_memory_command_sequencer_core.sv]
// Path: a request's first SPI slot passes through the queue, then the back end's slot
// shifter and output register, when the queue and output are empty.
// Rate: one slot per cycle at the output while the receiver is ready; a request causes
// at most 6 slots and holds the back end until they are sent; the front takes one request
// per cycle while the two-entry queue has room; requests that cause no slot are not queued.
// Reset (rst_n low, synchronous): mode idle, addresses, counts, mem_type zero, queue empty.
module spi_save_memory_command_sequencer_core #(
  parameter int FLASH_PAGE_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  spisq_chan_if.sink    in_ch,
  spisq_chan_if.sink    cfg_ch,
  spisq_chan_if.source  out_ch
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  spisq_pkg::job_t q_in_job;
  spisq_pkg::job_t q_out_job;

  // request decode and sequencing state
  spisq_front #(
    .FLASH_PAGE_BYTES (FLASH_PAGE_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_in_job)
  );

  // slot lists waiting for the back end
  spisq_fifo #(
    .item_t (spisq_pkg::job_t),
    .DEPTH  (spisq_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_out_job)
  );

  // one SPI slot per cycle toward the shifter while it is ready
  spisq_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_out_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[verif/spi_save_memory_command_sequencer_core_test.sv]
module spi_save_memory_command_sequencer_core_test;

  localparam int FLASH_PAGE = 256;
  localparam int RANDOM_REQUESTS = 100;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RUN_LIMIT = 3_000_000;

  // Opcodes the block has no meaning for
  localparam logic [2:0] OP_RESERVED_LO = 3'd6;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;

  logic clk;
  logic rst_n;

  spisq_chan_if #(.payload_t(spisq_pkg::in_req_t))  in_if ();
  spisq_chan_if #(.payload_t(spisq_pkg::cfg_req_t)) cfg_if ();
  spisq_chan_if #(.payload_t(spisq_pkg::out_req_t)) out_if ();

  spi_save_memory_command_sequencer_core #(
    .FLASH_PAGE_BYTES(FLASH_PAGE)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .cfg_ch (cfg_if),
    .out_ch (out_if)
  );

  // Sequencer state as seen from outside
  logic [1:0]  cur_mem_type;
  spisq_pkg::mode_t cur_mode;
  logic [23:0] next_addr;
  logic [24:0] stop_addr;
  logic [8:0]  page_bytes_done;
  logic [15:0] read_left;

  spisq_pkg::out_req_t batch[$];
  spisq_pkg::out_req_t pending_slots[$];
  spisq_pkg::out_req_t expected_slot;

  int mismatch_count = 0;
  int framed_requests = 0;
  int burst_left = 0;
  bit steady_feed = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_pattern = 0;
  int pattern_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------
  // Frame prediction
  // ---------------------------------------------------------------

  task automatic push_slot(logic [7:0] b, spisq_pkg::kind_t k, logic e);
    spisq_pkg::out_req_t s;
    s.spi_byte = b;
    s.byte_kind = k;
    s.end_frame = e;
    s.last = 1'b0;
    batch.push_back(s);
  endtask

  // Command byte plus the address bytes the device type takes
  task automatic push_header(logic [7:0] cmd, logic [23:0] a);
    case (cur_mem_type)
      spisq_pkg::MT_SMALL:
        push_slot(cmd | {4'b0, a[8], 3'b0}, spisq_pkg::KIND_SEND, 1'b0);
      spisq_pkg::MT_EEPROM: begin
        push_slot(cmd, spisq_pkg::KIND_SEND, 1'b0);
        push_slot(a[15:8], spisq_pkg::KIND_SEND, 1'b0);
      end
      default: begin
        push_slot(cmd, spisq_pkg::KIND_SEND, 1'b0);
        push_slot(a[23:16], spisq_pkg::KIND_SEND, 1'b0);
        push_slot(a[15:8], spisq_pkg::KIND_SEND, 1'b0);
      end
    endcase
    push_slot(a[7:0], spisq_pkg::KIND_SEND, 1'b0);
  endtask

  function automatic int unsigned page_size();
    case (cur_mem_type)
      spisq_pkg::MT_SMALL:  return spisq_pkg::PAGE_SMALL;
      spisq_pkg::MT_EEPROM: return spisq_pkg::PAGE_EEPROM;
      default:              return FLASH_PAGE;
    endcase
  endfunction

  task automatic open_page();
    push_slot(spisq_pkg::CMD_WREN, spisq_pkg::KIND_SEND, 1'b1);
    push_header(spisq_pkg::CMD_WRITE, next_addr);
    page_bytes_done = '0;
    cur_mode = spisq_pkg::MODE_WRITE;
  endtask

  task automatic reset_sequencer_state();
    cur_mem_type = spisq_pkg::MT_NONE;
    cur_mode = spisq_pkg::MODE_IDLE;
    next_addr = '0;
    stop_addr = '0;
    page_bytes_done = '0;
    read_left = '0;
  endtask

  // Works out the SPI slots one accepted request causes
  task automatic sequence_request(spisq_pkg::in_req_t r, output int produced);
    logic [24:0] nxt;
    logic done;
    spisq_pkg::out_req_t s;
    batch.delete();
    case (r.opcode)
      spisq_pkg::OP_START_READ: begin
        if (cur_mode == spisq_pkg::MODE_IDLE && cur_mem_type != spisq_pkg::MT_NONE) begin
          push_header(spisq_pkg::CMD_READ, r.address);
          if (r.byte_count == '0) begin
            s = batch.pop_back();
            s.end_frame = 1'b1;
            batch.push_back(s);
          end else begin
            read_left = r.byte_count;
            cur_mode = spisq_pkg::MODE_READ;
          end
        end
      end
      spisq_pkg::OP_READ_SLOT: begin
        if (cur_mode == spisq_pkg::MODE_READ) begin
          read_left = read_left - 16'd1;
          if (read_left == '0) begin
            push_slot(8'h00, spisq_pkg::KIND_RECV, 1'b1);
            cur_mode = spisq_pkg::MODE_IDLE;
          end else begin
            push_slot(8'h00, spisq_pkg::KIND_RECV, 1'b0);
          end
        end else if (cur_mode == spisq_pkg::MODE_POLL) begin
          push_slot(8'h00, spisq_pkg::KIND_RECV, 1'b0);
        end
      end
      spisq_pkg::OP_START_WRITE: begin
        if (cur_mode == spisq_pkg::MODE_IDLE && cur_mem_type != spisq_pkg::MT_NONE &&
            r.byte_count != '0) begin
          next_addr = r.address;
          stop_addr = {1'b0, r.address} + r.byte_count;
          open_page();
        end
      end
      spisq_pkg::OP_WRITE_BYTE: begin
        if (cur_mode == spisq_pkg::MODE_WRITE) begin
          nxt = {1'b0, next_addr} + 25'd1;
          page_bytes_done = page_bytes_done + 9'd1;
          done = 1'b0;
          // Last byte of the request, or the top of the address space
          if (nxt >= stop_addr || nxt > 25'hFF_FFFF) begin
            nxt[24] = 1'b0;
            stop_addr = nxt;
            done = 1'b1;
          end
          next_addr = nxt[23:0];
          if (done || page_bytes_done >= page_size()) begin
            push_slot(r.data_byte, spisq_pkg::KIND_SEND, 1'b1);
            push_slot(spisq_pkg::CMD_RDSR, spisq_pkg::KIND_SEND, 1'b0);
            cur_mode = spisq_pkg::MODE_POLL;
          end else begin
            push_slot(r.data_byte, spisq_pkg::KIND_SEND, 1'b0);
          end
        end
      end
      spisq_pkg::OP_STATUS: begin
        if (cur_mode == spisq_pkg::MODE_POLL) begin
          if (r.data_byte[0]) begin
            push_slot(8'h00, spisq_pkg::KIND_RECV, 1'b0);
          end else begin
            push_slot(8'h00, spisq_pkg::KIND_DESEL, 1'b1);
            // Next page unless done or the device type was cleared
            if ({1'b0, next_addr} < stop_addr && cur_mem_type != spisq_pkg::MT_NONE) begin
              open_page();
            end else begin
              cur_mode = spisq_pkg::MODE_IDLE;
            end
          end
        end
      end
      spisq_pkg::OP_ERASE: begin
        if (cur_mode == spisq_pkg::MODE_IDLE && cur_mem_type == spisq_pkg::MT_FLASH) begin
          next_addr = {r.address[23:16], 16'h0000};
          stop_addr = {1'b0, next_addr};
          push_slot(spisq_pkg::CMD_WREN, spisq_pkg::KIND_SEND, 1'b1);
          push_slot(spisq_pkg::CMD_SE, spisq_pkg::KIND_SEND, 1'b0);
          push_slot(r.address[23:16], spisq_pkg::KIND_SEND, 1'b0);
          push_slot(8'h00, spisq_pkg::KIND_SEND, 1'b0);
          push_slot(8'h00, spisq_pkg::KIND_SEND, 1'b1);
          push_slot(spisq_pkg::CMD_RDSR, spisq_pkg::KIND_SEND, 1'b0);
          cur_mode = spisq_pkg::MODE_POLL;
        end
      end
      default: ;
    endcase
    produced = batch.size();
    if (produced > 0) begin
      s = batch.pop_back();
      s.last = 1'b1;
      batch.push_back(s);
    end
    foreach (batch[i]) pending_slots.push_back(batch[i]);
  endtask

  // ---------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_slots.size() == 0) begin
        report_mismatch($sformatf("unexpected slot byte %02h kind %0d",
                                  out_if.payload.spi_byte, out_if.payload.byte_kind));
      end else begin
        expected_slot = pending_slots.pop_front();
        if (out_if.payload.spi_byte !== expected_slot.spi_byte)
          report_mismatch($sformatf("spi_byte got %02h expected %02h",
                                    out_if.payload.spi_byte, expected_slot.spi_byte));
        if (out_if.payload.byte_kind !== expected_slot.byte_kind)
          report_mismatch($sformatf("byte_kind got %0d expected %0d",
                                    out_if.payload.byte_kind, expected_slot.byte_kind));
        if (out_if.payload.end_frame !== expected_slot.end_frame)
          report_mismatch($sformatf("end_frame got %0b expected %0b",
                                    out_if.payload.end_frame, expected_slot.end_frame));
        if (out_if.payload.last !== expected_slot.last)
          report_mismatch($sformatf("last got %0b expected %0b",
                                    out_if.payload.last, expected_slot.last));
      end
    end
  end

  // Receiver: changing stall patterns, plus long hold-offs on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (pattern_left == 0) begin
        stall_pattern = $urandom_range(0, 3);
        pattern_left = $urandom_range(20, 80);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        case (stall_pattern)
          0: out_if.ready = 1'b1;
          1: out_if.ready = 1'($urandom_range(0, 1));
          2: out_if.ready = (pattern_left % 3 == 0);
          default: out_if.ready = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------

  function automatic spisq_pkg::in_req_t make_req(logic [2:0] op, logic [23:0] a,
                                                  logic [15:0] c, logic [7:0] d);
    spisq_pkg::in_req_t r;
    r.opcode = op;
    r.address = a;
    r.byte_count = c;
    r.data_byte = d;
    return r;
  endfunction

  // Sends one request in bursts with random gaps, then predicts its slots
  task automatic send_request(spisq_pkg::in_req_t r);
    int gap;
    int produced;
    if (!steady_feed && burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.payload = r;
    do @(posedge clk); while (!in_if.ready);
    sequence_request(r, produced);
    if (produced > 0) framed_requests++;
  endtask

  // Stop offering requests and let every expected slot come out
  task automatic wait_for_bus_quiet();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mem_type(logic [1:0] t);
    wait_for_bus_quiet();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.payload.mem_type = t;
    do @(posedge clk); while (!cfg_if.ready);
    cur_mem_type = t;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Mostly well-formed requests for the current mode, some noise
  function automatic spisq_pkg::in_req_t next_request();
    int unsigned roll;
    spisq_pkg::in_req_t r;
    roll = $urandom_range(0, 99);
    r = make_req(3'($urandom_range(0, 7)), 24'($urandom), 16'($urandom), 8'($urandom));
    // Keep noise starts short so a read cannot lock the block for ages
    if (cur_mode == spisq_pkg::MODE_IDLE && (r.opcode == spisq_pkg::OP_START_READ ||
                                             r.opcode == spisq_pkg::OP_START_WRITE))
      r.byte_count = 16'($urandom_range(0, 8));
    if (roll >= 90) return r;
    case (cur_mode)
      spisq_pkg::MODE_IDLE: begin
        if (roll < 30) begin
          r.opcode = spisq_pkg::OP_START_READ;
          r.byte_count = 16'($urandom_range(0, 6));
        end else if (roll < 65) begin
          r.opcode = spisq_pkg::OP_START_WRITE;
          if ($urandom_range(0, 9) == 0) begin
            r.address = 24'hFF_FFFF - 24'($urandom_range(0, 20));
            r.byte_count = 16'($urandom);
          end else begin
            r.byte_count = 16'($urandom_range(1, 40));
          end
        end else if (roll < 80) begin
          r.opcode = spisq_pkg::OP_ERASE;
        end
      end
      spisq_pkg::MODE_READ:  r.opcode = spisq_pkg::OP_READ_SLOT;
      spisq_pkg::MODE_WRITE: r.opcode = spisq_pkg::OP_WRITE_BYTE;
      default: begin
        if (roll < 15) begin
          r.opcode = spisq_pkg::OP_READ_SLOT;
        end else begin
          r.opcode = spisq_pkg::OP_STATUS;
          r.data_byte[0] = ($urandom_range(0, 9) < 4);
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------

  // No device type after reset: every request is dropped
  task automatic test_no_device();
    send_request(make_req(spisq_pkg::OP_START_READ, 24'h000100, 16'd3, 8'h00));
    send_request(make_req(spisq_pkg::OP_START_WRITE, 24'h000000, 16'd5, 8'h00));
    send_request(make_req(spisq_pkg::OP_ERASE, 24'hFF0000, 16'd0, 8'h00));
    send_request(make_req(OP_RESERVED_HI, 24'hFF_FFFF, 16'hFFFF, 8'hFF));
    send_request(make_req(spisq_pkg::OP_STATUS, 24'h000000, 16'd0, 8'h00));
    send_request(make_req(spisq_pkg::OP_WRITE_BYTE, 24'h000000, 16'd0, 8'hA5));
  endtask

  // Read headers for each type, zero count, and a stray slot
  task automatic test_read_frames();
    write_mem_type(spisq_pkg::MT_SMALL);
    send_request(make_req(spisq_pkg::OP_START_READ, 24'h0001FF, 16'd2, 8'h00));
    send_request(make_req(spisq_pkg::OP_READ_SLOT, 24'h000000, 16'd0, 8'h00));
    send_request(make_req(spisq_pkg::OP_READ_SLOT, 24'h000000, 16'd0, 8'h00));
    send_request(make_req(spisq_pkg::OP_READ_SLOT, 24'h000000, 16'd0, 8'h00));
    write_mem_type(spisq_pkg::MT_EEPROM);
    send_request(make_req(spisq_pkg::OP_START_READ, 24'hFF_FFFF, 16'd0, 8'h00));
    write_mem_type(spisq_pkg::MT_FLASH);
    send_request(make_req(spisq_pkg::OP_START_READ, 24'h000000, 16'd1, 8'h00));
    send_request(make_req(spisq_pkg::OP_READ_SLOT, 24'h000000, 16'd0, 8'h00));
  endtask

  // A write that runs past the top of the address space stops there
  task automatic test_write_top_of_space();
    send_request(make_req(spisq_pkg::OP_START_WRITE, 24'hFF_FFFE, 16'd0, 8'h00));
    send_request(make_req(spisq_pkg::OP_START_WRITE, 24'hFF_FFFE, 16'hFFFF, 8'h00));
    send_request(make_req(spisq_pkg::OP_WRITE_BYTE, 24'h000000, 16'd0, 8'hFF));
    send_request(make_req(spisq_pkg::OP_WRITE_BYTE, 24'h000000, 16'd0, 8'h00));
    send_request(make_req(spisq_pkg::OP_READ_SLOT, 24'h000000, 16'd0, 8'h00));
    send_request(make_req(spisq_pkg::OP_STATUS, 24'h000000, 16'd0, 8'h01));
    send_request(make_req(spisq_pkg::OP_STATUS, 24'h000000, 16'd0, 8'hFE));
    send_request(make_req(spisq_pkg::OP_STATUS, 24'h000000, 16'd0, 8'h00));
  endtask

  // Sector erase on flash, and erase dropped on an EEPROM
  task automatic test_sector_erase();
    send_request(make_req(spisq_pkg::OP_ERASE, 24'hABCDEF, 16'd0, 8'h00));
    send_request(make_req(spisq_pkg::OP_STATUS, 24'h000000, 16'd0, 8'hFF));
    send_request(make_req(spisq_pkg::OP_STATUS, 24'h000000, 16'd0, 8'h00));
    write_mem_type(spisq_pkg::MT_EEPROM);
    send_request(make_req(spisq_pkg::OP_ERASE, 24'h120000, 16'd0, 8'h00));
    send_request(make_req(OP_RESERVED_LO, 24'h000000, 16'd4, 8'h00));
  endtask

  // Full small-EEPROM page, then the device type is cleared while polling
  task automatic test_type_change_mid_write();
    write_mem_type(spisq_pkg::MT_SMALL);
    send_request(make_req(spisq_pkg::OP_START_WRITE, 24'h0001F8, 16'd20, 8'h00));
    repeat (spisq_pkg::PAGE_SMALL)
      send_request(make_req(spisq_pkg::OP_WRITE_BYTE, 24'h000000, 16'd0, 8'($urandom)));
    write_mem_type(spisq_pkg::MT_NONE);
    send_request(make_req(spisq_pkg::OP_STATUS, 24'h000000, 16'd0, 8'h00));
    send_request(make_req(spisq_pkg::OP_START_READ, 24'h000010, 16'd1, 8'h00));
  endtask

  // Receiver holds off while a long flash write streams in without gaps
  task automatic test_backpressure();
    write_mem_type(spisq_pkg::MT_FLASH);
    steady_feed = 1'b1;
    hold_req = HOLD_OFF_CYCLES;
    send_request(make_req(spisq_pkg::OP_START_WRITE, 24'($urandom_range(0, 24'hF0_0000)),
                          16'(FLASH_PAGE + 2), 8'h00));
    while (cur_mode != spisq_pkg::MODE_IDLE) begin
      if (cur_mode == spisq_pkg::MODE_WRITE)
        send_request(make_req(spisq_pkg::OP_WRITE_BYTE, 24'($urandom), 16'($urandom),
                              8'($urandom)));
      else
        send_request(make_req(spisq_pkg::OP_STATUS, 24'($urandom), 16'($urandom),
                              {7'($urandom), 1'($urandom_range(0, 9) < 3)}));
    end
    steady_feed = 1'b0;
    wait_for_bus_quiet();
  endtask

  // Random request streams with occasional type changes
  task automatic test_random_traffic();
    int target;
    target = framed_requests + RANDOM_REQUESTS;
    while (framed_requests < target) begin
      if ((cur_mode == spisq_pkg::MODE_IDLE &&
           $urandom_range(0, (cur_mem_type == spisq_pkg::MT_NONE) ? 2 : 14) == 0) ||
          (cur_mode == spisq_pkg::MODE_POLL && $urandom_range(0, 39) == 0))
        write_mem_type(2'($urandom_range(0, 3)));
      send_request(next_request());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    reset_sequencer_state();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_no_device();
    test_read_frames();
    test_write_top_of_space();
    test_sector_erase();
    test_type_change_mid_write();
    test_backpressure();
    test_random_traffic();

    wait_for_bus_quiet();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
design/spisq_pkg.sv
design/spisq_chan_if.sv
design/spisq_fifo.sv
design/spisq_front.sv
design/spisq_back.sv
design/spi_save_memory_command_sequencer_core.sv
verif/spi_save_memory_command_sequencer_core_test.sv
